// ===== src/atg_pkg.sv =====
// ----------------------------------------------------------------------------
// atg_pkg: shared types and constants of the amplifier thermal guard
// Holds the item and configuration types, operation and status codes, and
// the thermistor curve table that is built at elaboration time.
// ----------------------------------------------------------------------------
package atg_pkg;

  // Converter, reference voltage and curve table sizing.
  localparam int AdcBits       = 12;
  localparam int VrefMv        = 3300;
  localparam int CurveRomDepth = 256;

  // Field widths of the item format.
  localparam int AdcW    = 12;
  localparam int StampW  = 32;
  localparam int VoltW   = 16;
  localparam int ReadW   = 10;
  localparam int TempW   = 11;
  localparam int LimitW  = 11;
  localparam int RomAddrW = $clog2(CurveRomDepth);

  // Stream port widths.
  localparam int InDataW  = 48;
  localparam int OutDataW = 16;

  // Filter divider: floor(sum / 5) as a multiply by a rounded-up reciprocal.
  localparam int FiltSumW  = VoltW + 3;
  localparam int Div5Shift = FiltSumW + 3;
  localparam int Recip5W   = Div5Shift - 1;
  localparam logic [Recip5W-1:0] Recip5 =
    Recip5W'(((64'd1 << Div5Shift) + 64'd4) / 64'd5);

  // Register reset values.
  localparam logic [7:0]  MinTempRst  = 8'd30;
  localparam logic [9:0]  MaxTempRst  = 10'd65;
  localparam logic [10:0] HystRst     = 11'd963;
  localparam logic [31:0] HoldMsRst   = 32'd10000;
  localparam logic [LimitW-1:0] HystLimitRst = LimitW'((65 * 963) >> 10);

  // Operation carried by an input transaction.
  typedef enum logic [1:0] {
    OpSample   = 2'd0,
    OpShutdown = 2'd1,
    OpEnable   = 2'd2,
    OpDisable  = 2'd3
  } op_e;

  // Amplifier status reported with every result.
  typedef enum logic [1:0] {
    StOff      = 2'd0,
    StOk       = 2'd1,
    StHigh     = 2'd2,
    StShutdown = 2'd3
  } status_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    RegMinTemp = 2'd0,
    RegMaxTemp = 2'd1,
    RegHyst    = 2'd2,
    RegHoldMs  = 2'd3
  } cfg_reg_e;

  // Configuration values as seen by the datapath.
  typedef struct packed {
    logic [7:0]        floor_temp;
    logic [9:0]        high_temp;
    logic [LimitW-1:0] hyst_limit;
    logic [31:0]       hold_ms;
  } cfg_t;

  // Converted sample handed from the scaling pipeline to the state stage.
  typedef struct packed {
    op_e              op;
    logic [StampW-1:0] now_ms;
    logic [VoltW-1:0] volt_mv;
    logic             in_range;
  } smp_t;

  // Thermistor curve in Q28 fixed point.
  localparam longint unsigned OneQ28   = 64'd1 << 28;
  localparam longint unsigned CoefAQ28 = (64'd1165930842 << 28) / 64'd100000000;
  localparam longint unsigned CoefBQ28 = (64'd261100466 << 28) / 64'd100000000;

  typedef logic [CurveRomDepth-1:0][ReadW-1:0] curve_rom_t;

  // Unsigned quotient by shift and subtract, used only while building tables.
  function automatic longint unsigned udiv64(longint unsigned num,
                                             longint unsigned den);
    longint unsigned quo, rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | ((num >> b) & 64'd1);
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | (64'd1 << b);
      end
    end
    return quo;
  endfunction

  // Each entry is a * exp(b / v) at the bin midpoint, saturated to 1023.
  // The exponential uses a 16-term series on x/8 squared three times.
  function automatic curve_rom_t build_curve_rom();
    curve_rom_t rom;
    longint unsigned k, i, vq4, x, y, term, sum, prod;
    rom = '0;
    for (k = 0; k < CurveRomDepth; k++) begin
      vq4 = udiv64((2 * k + 1) << 15, 64'(CurveRomDepth));
      if (vq4 == 0) begin
        rom[k] = 10'd1023;
      end else begin
        x = udiv64(CoefBQ28 * 64'd16000, vq4);
        if (x > 5 * OneQ28) begin
          rom[k] = 10'd1023;
        end else begin
          y    = x >> 3;
          term = OneQ28;
          sum  = OneQ28;
          for (i = 1; i <= 16; i++) begin
            term = udiv64((term * y) >> 28, i);
            sum  = sum + term;
          end
          for (i = 0; i < 3; i++) begin
            sum = (sum * sum) >> 28;
          end
          prod = CoefAQ28 * (sum >> 14);
          prod = (prod + (64'd1 << 41)) >> 42;
          rom[k] = (prod > 1023) ? 10'd1023 : prod[9:0];
        end
      end
    end
    return rom;
  endfunction

  localparam curve_rom_t CurveRom = build_curve_rom();

endpackage

// ===== src/atg_cfg.sv =====
// ----------------------------------------------------------------------------
// atg_cfg: configuration registers of the amplifier thermal guard
// Stores the four registers and keeps the hysteresis threshold, which is the
// high temperature threshold scaled by the Q10 factor, in a register of its own.
// ----------------------------------------------------------------------------
module atg_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  atg_pkg::cfg_reg_e cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  output atg_pkg::cfg_t     cfg_o
);
  import atg_pkg::*;

  logic [7:0]        floor_temp_q;
  logic [9:0]        high_temp_q;
  logic [10:0]       hyst_q;
  logic [31:0]       hold_ms_q;
  logic [LimitW-1:0] limit_q;
  logic [LimitW-1:0] limit_d;
  logic [20:0]       limit_prod;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Register write decode.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_temp_q <= MinTempRst;
      high_temp_q  <= MaxTempRst;
      hyst_q       <= HystRst;
      hold_ms_q    <= HoldMsRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegMinTemp: floor_temp_q <= cfg_data_i[7:0];
        RegMaxTemp: high_temp_q  <= cfg_data_i[9:0];
        RegHyst:    hyst_q       <= cfg_data_i[10:0];
        RegHoldMs:  hold_ms_q    <= cfg_data_i;
      endcase
    end
  end

  // Threshold used while the status is high, truncated Q10 product.
  assign limit_prod = 21'(high_temp_q) * 21'(hyst_q);
  assign limit_d    = limit_prod[20:10];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= HystLimitRst;
    end else begin
      limit_q <= limit_d;
    end
  end

  assign cfg_o.floor_temp = floor_temp_q;
  assign cfg_o.high_temp  = high_temp_q;
  assign cfg_o.hyst_limit = limit_q;
  assign cfg_o.hold_ms    = hold_ms_q;

endmodule

// ===== src/atg_scale.sv =====
// ----------------------------------------------------------------------------
// atg_scale: sample to millivolt conversion pipeline
// Registers the incoming transaction, multiplies the converter code by the
// reference scale, then divides by full scale with a reciprocal multiply.
// Holds no state across items, so it runs one item per cycle unless its output stalls.
// ----------------------------------------------------------------------------
module atg_scale (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  atg_pkg::op_e                in_op_i,
  input  logic [atg_pkg::AdcW-1:0]    in_adc_i,
  input  logic [atg_pkg::StampW-1:0]  in_now_i,
  output logic                        smp_valid_o,
  input  logic                        smp_ready_i,
  output atg_pkg::smp_t               smp_o
);
  import atg_pkg::*;

  localparam int AdcMax     = (1 << AdcBits) - 1;
  localparam int AdcLowCode = (1000 * AdcMax) / VrefMv;
  localparam int VoltScale  = VrefMv * 16;
  localparam int VScaleW    = $clog2(VoltScale + 1);
  localparam int ProdW      = AdcW + VScaleW;
  localparam int RecipShift = ProdW + AdcBits;
  localparam int RecipW     = RecipShift - AdcBits + 1;
  localparam int MulW       = ProdW + RecipW;
  localparam int QuotW      = MulW - RecipShift;
  localparam logic [RecipW-1:0] RecipM =
    RecipW'(((64'd1 << RecipShift) + 64'(AdcMax) - 64'd1) / 64'(AdcMax));

  // Input register.
  logic              in_valid_q;
  op_e               in_op_q;
  logic [AdcW-1:0]   in_adc_q;
  logic [StampW-1:0] in_now_q;

  // Product register.
  logic              a_valid_q;
  op_e               a_op_q;
  logic [StampW-1:0] a_now_q;
  logic [ProdW-1:0]  a_prod_q;
  logic              a_inr_q;

  // Voltage register.
  logic              b_valid_q;
  smp_t              b_q;

  logic              a_ready;
  logic              b_ready;
  logic [AdcW-1:0]   adc_masked;
  logic [ProdW-1:0]  prod_d;
  logic              inr_d;
  logic [MulW-1:0]   mul;
  logic [QuotW-1:0]  quot;
  logic [VoltW-1:0]  volt_d;

  // Each stage moves when it is empty or its successor moves.
  assign b_ready    = !b_valid_q || smp_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = !in_valid_q || a_ready;

  // Code above the 1 V point, and code times the reference scale.
  assign adc_masked = in_adc_q & AdcW'(AdcMax);
  assign inr_d      = 32'(adc_masked) > 32'(AdcLowCode);
  assign prod_d     = ProdW'(adc_masked) * ProdW'(VoltScale);

  // Division by full scale, saturated to the millivolt word.
  assign mul    = MulW'(a_prod_q) * MulW'(RecipM);
  assign quot   = mul[MulW-1:RecipShift];
  assign volt_d = (quot > QuotW'({VoltW{1'b1}})) ? {VoltW{1'b1}} : quot[VoltW-1:0];

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      a_valid_q  <= 1'b0;
      b_valid_q  <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (a_ready)    a_valid_q  <= in_valid_q;
      if (b_ready)    b_valid_q  <= a_valid_q;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_op_q  <= in_op_i;
      in_adc_q <= in_adc_i;
      in_now_q <= in_now_i;
    end
    if (a_ready && in_valid_q) begin
      a_op_q   <= in_op_q;
      a_now_q  <= in_now_q;
      a_prod_q <= prod_d;
      a_inr_q  <= inr_d;
    end
    if (b_ready && a_valid_q) begin
      b_q.op       <= a_op_q;
      b_q.now_ms   <= a_now_q;
      b_q.volt_mv  <= volt_d;
      b_q.in_range <= a_inr_q;
    end
  end

  assign smp_valid_o = b_valid_q;
  assign smp_o       = b_q;

endmodule

// ===== src/atg_core.sv =====
// ----------------------------------------------------------------------------
// atg_core: filter, curve lookup, validity and status stage
// Applies one converted sample to the guard state and writes the result
// into the output register.
// ----------------------------------------------------------------------------
module atg_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  atg_pkg::cfg_t               cfg_i,
  input  logic                        smp_valid_i,
  output logic                        smp_ready_o,
  input  atg_pkg::smp_t               smp_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic [atg_pkg::TempW-1:0]   res_temp_o,
  output logic                        res_temp_valid_o,
  output atg_pkg::status_e            res_status_o,
  output logic                        res_changed_o
);
  import atg_pkg::*;

  localparam int DivProdW = FiltSumW + Recip5W;
  localparam int AddrProdW = VoltW + RomAddrW + 1;

  // Guard state.
  logic [VoltW-1:0]        filt_q, filt_d;
  logic [ReadW-1:0]        cur_q, cur_d;
  logic [ReadW-1:0]        prev_q, prev_d;
  logic signed [TempW-1:0] rep_q, rep_d;
  logic                    ok_q, ok_d;
  status_e                 status_q, status_d;
  logic                    run_q, run_d;
  logic [StampW-1:0]       stamp_q, stamp_d;

  // Result register.
  logic                    out_valid_q;
  logic                    changed_q;
  logic                    changed_d;

  logic                    take;
  logic signed [TempW-1:0] inval_temp;
  logic [FiltSumW-1:0]     filt_sum;
  logic [DivProdW-1:0]     div_prod;
  logic [VoltW-1:0]        filt_new;
  logic [AddrProdW-1:0]    addr_prod;
  logic [AddrProdW-17:0]   addr_full;
  logic [RomAddrW-1:0]     rom_addr;
  logic [ReadW-1:0]        cur_new;
  logic                    step_ok;
  logic                    meas_ok;
  logic signed [TempW-1:0] meas_temp;
  logic [StampW-1:0]       elapsed;
  logic                    holding;
  status_e                 base_status;
  status_e                 target;
  logic [LimitW-1:0]       limit;
  logic                    do_eval;

  assign smp_ready_o = !out_valid_q || res_ready_i;
  assign take        = smp_valid_i && smp_ready_o;

  // Reported value for an invalid reading.
  assign inval_temp = $signed({3'b000, cfg_i.floor_temp} - 11'd1);

  // Smoothing filter: (2 * old + 3 * new) / 5 by reciprocal multiply.
  assign filt_sum = (FiltSumW'(filt_q) << 1) + FiltSumW'(smp_i.volt_mv) * FiltSumW'(3);
  assign div_prod = DivProdW'(filt_sum) * DivProdW'(Recip5);
  assign filt_new = div_prod[Div5Shift+VoltW-1:Div5Shift];

  // Curve table address from the filtered voltage.
  assign addr_prod = AddrProdW'(filt_new) * AddrProdW'(CurveRomDepth);
  assign addr_full = addr_prod[AddrProdW-1:16];
  assign rom_addr  = (addr_full >= (AddrProdW-16)'(CurveRomDepth)) ?
                     RomAddrW'(CurveRomDepth - 1) : addr_full[RomAddrW-1:0];
  assign cur_new   = CurveRom[rom_addr];

  // The reading moved at most one degree and is not below the minimum.
  assign step_ok = ({1'b0, cur_new} <= {1'b0, cur_q} + 11'd1) &&
                   ({1'b0, cur_q} <= {1'b0, cur_new} + 11'd1) &&
                   (cur_new >= {2'b00, cfg_i.floor_temp});
  assign meas_ok   = smp_i.in_range && step_ok;
  assign meas_temp = meas_ok ? $signed({1'b0, cur_new}) : inval_temp;

  // Shutdown hold by wrap-safe elapsed time.
  assign elapsed     = smp_i.now_ms - stamp_q;
  assign holding     = (status_q == StShutdown) && (elapsed < cfg_i.hold_ms);
  assign base_status = (status_q == StShutdown) ? StOk : status_q;
  assign limit       = (base_status == StHigh) ? cfg_i.hyst_limit
                                               : LimitW'(cfg_i.high_temp);
  assign target      = ($signed({meas_temp[TempW-1], meas_temp}) <
                        $signed({1'b0, limit})) ? StOk : StHigh;

  assign do_eval = (smp_i.op == OpEnable) || ((smp_i.op == OpSample) && run_q);

  // Next guard state for the transaction in hand.
  always_comb begin
    filt_d    = filt_q;
    cur_d     = cur_q;
    prev_d    = prev_q;
    rep_d     = rep_q;
    ok_d      = ok_q;
    status_d  = status_q;
    run_d     = run_q;
    stamp_d   = stamp_q;
    changed_d = 1'b0;
    case (smp_i.op)
      OpShutdown: begin
        if (status_q != StShutdown) begin
          status_d  = StShutdown;
          stamp_d   = smp_i.now_ms;
          changed_d = 1'b1;
        end
      end
      OpDisable: begin
        run_d = 1'b0;
        rep_d = inval_temp;
        ok_d  = 1'b0;
        if (status_q != StOff) begin
          status_d  = StOff;
          changed_d = 1'b1;
        end
      end
      OpEnable: begin
        run_d = 1'b1;
      end
      default: begin
      end
    endcase
    if (do_eval) begin
      if (smp_i.in_range) begin
        filt_d = filt_new;
        prev_d = cur_q;
        cur_d  = cur_new;
      end
      rep_d = meas_temp;
      ok_d  = meas_ok;
      if (!holding) begin
        status_d  = target;
        changed_d = (target != base_status);
      end
    end
  end

  // Control state and result handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q      <= '0;
      cur_q       <= '0;
      prev_q      <= '0;
      rep_q       <= $signed({3'b000, MinTempRst} - 11'd1);
      ok_q        <= 1'b0;
      status_q    <= StOff;
      run_q       <= 1'b0;
      stamp_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        filt_q   <= filt_d;
        cur_q    <= cur_d;
        prev_q   <= prev_d;
        rep_q    <= rep_d;
        ok_q     <= ok_d;
        status_q <= status_d;
        run_q    <= run_d;
        stamp_q  <= stamp_d;
      end
      if (smp_ready_o) begin
        out_valid_q <= smp_valid_i;
      end
    end
  end

  // Change flag travels with the result.
  always_ff @(posedge clk_i) begin
    if (take) begin
      changed_q <= changed_d;
    end
  end

  assign res_valid_o      = out_valid_q;
  assign res_temp_o       = rep_q;
  assign res_temp_valid_o = ok_q;
  assign res_status_o     = status_q;
  assign res_changed_o    = changed_q;

endmodule

// ===== src/amp_thermal_guard.sv =====
// ----------------------------------------------------------------------------
// amp_thermal_guard: thermistor temperature guard for a power amplifier
//
//   Channel   Direction  Transaction carries
//   s_axis    in         tuser: operation; tdata: adc_sample, now_ms
//   m_axis    out        tuser: temp_valid; tdata: temperature, amp_status,
//                        status_changed
//   cfg       in         cfg_index_i: register index; cfg_data_i: value
//
// One item is accepted per cycle while m_axis does not stall; its result
// passes the input, product, voltage and result registers before it is
// presented. The rate is set by the filter, curve lookup and status
// update, which close their state loop through the guard state registers.
// Reset is asynchronous, active low, and needs no clearing pass. A stall
// on m_axis backs up through the pipeline stage by stage and holds
// s_axis_tready low once all are full.
// ----------------------------------------------------------------------------
module amp_thermal_guard (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // [11:0] adc_sample, [43:12] now_ms, [47:44] zero
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [atg_pkg::InDataW-1:0]    s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [10:0] temperature, [12:11] amp_status, [13] status_changed
  output logic [atg_pkg::OutDataW-1:0]   m_axis_tdata,
  // [0] temp_valid
  output logic                           m_axis_tuser,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);
  import atg_pkg::*;

  cfg_t              cfg;
  logic              smp_valid;
  logic              smp_ready;
  smp_t              smp;
  logic [TempW-1:0]  res_temp;
  status_e           res_status;
  logic              res_changed;

  // Configuration registers.
  atg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_reg_e'(cfg_index_i)),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Converter code to millivolts.
  atg_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (op_e'(s_axis_tuser)),
    .in_adc_i    (s_axis_tdata[AdcW-1:0]),
    .in_now_i    (s_axis_tdata[AdcW+StampW-1:AdcW]),
    .smp_valid_o (smp_valid),
    .smp_ready_i (smp_ready),
    .smp_o       (smp)
  );

  // Guard state and result register.
  atg_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .smp_valid_i      (smp_valid),
    .smp_ready_o      (smp_ready),
    .smp_i            (smp),
    .res_valid_o      (m_axis_tvalid),
    .res_ready_i      (m_axis_tready),
    .res_temp_o       (res_temp),
    .res_temp_valid_o (m_axis_tuser),
    .res_status_o     (res_status),
    .res_changed_o    (res_changed)
  );

  assign m_axis_tdata = {2'b00, res_changed, res_status, res_temp};

endmodule
